>>> src/imhq_pkg.sv
// Package for the indexed max-heap queue: command and status codes and the
// sequencer state type. No dependencies.
package imhq_pkg;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_EXTRACT = 2'd1;
   localparam logic [1:0] CMD_CHANGE  = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_PRESENT = 3'd3;
   localparam logic [2:0] ST_ABSENT  = 3'd4;

   localparam int ID_COUNT = 256;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_CH_POS = 11'b00000000010,
      S_UP_RD  = 11'b00000000100,
      S_UP_CMP = 11'b00000001000,
      S_DN_RL  = 11'b00000010000,
      S_DN_RR  = 11'b00000100000,
      S_DN_CMP = 11'b00001000000,
      S_EX_RD1 = 11'b00010000000,
      S_EX_GET = 11'b00100000000,
      S_PLACE  = 11'b01000000000,
      S_FIN    = 11'b10000000000
   } state_type;

endpackage

>>> src/indexed_max_heap_queue.sv
// Indexed binary max-heap priority queue: heap memory, id-to-slot map and
// the sift sequencer. Depends on imhq_pkg.
//
// Usage: one command per req_ beat (insert, extract maximum, change
// priority). Each command gives exactly one rsp_ beat carrying the removed
// id, a status code, the entry count after the command and an empty flag.
// req_ready is high only while the sequencer is idle; one command is worked
// on at a time. The heap is one memory with a single registered read port,
// so each level of a sift up steps through S_UP_RD and S_UP_CMP, and each
// level of a sink through S_DN_RL, S_DN_RR and S_DN_CMP. The result sits in
// an output register; the sequencer may accept the next command while it
// waits, and stalls at its final step if the previous result has still not
// been taken.
// Reset (synchronous) empties the queue and marks all ids absent; heap and
// map memories are not cleared, as only written entries are ever used.
module indexed_max_heap_queue import imhq_pkg::*; #(
   parameter int CAPACITY   = 256,
   parameter int PRIO_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_item_id,
   input  logic [31:0] req_priority_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_removed_id,
   output logic [2:0]  rsp_status,
   output logic [8:0]  rsp_entry_count,
   output logic        rsp_is_empty
);

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = SW + 2;
   localparam int TW = (PRIO_WIDTH < 32) ? PRIO_WIDTH : 32;

   typedef struct packed {
      logic [7:0]                   id;
      logic signed [PRIO_WIDTH-1:0] prio;
   } entry_type;

   entry_type heap_ff [CAPACITY];
   logic [SW-1:0] map_ff [ID_COUNT];

   entry_type heap_rd_ff;
   logic [SW-1:0] map_rd_ff;

   state_type state_ff, state_in;
   logic [SW-1:0] pos_ff, pos_in;
   entry_type cur_ff, cur_in, left_ff, left_in;
   logic sink_ff, sink_in;
   logic [7:0] removed_ff, removed_in;
   logic [2:0] status_ff, status_in;
   logic [CW-1:0] count_ff, count_in;
   logic [ID_COUNT-1:0] present_ff, present_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_removed_ff, rsp_removed_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [8:0] rsp_count_ff, rsp_count_in;
   logic rsp_empty_ff, rsp_empty_in;

   logic heap_we, map_we;
   logic [SW-1:0] heap_waddr, heap_raddr;
   entry_type heap_wdata;
   logic [SW-1:0] map_wdata;
   logic [7:0] map_raddr, map_waddr;

   logic signed [TW-1:0] prio_trunc;
   logic signed [PRIO_WIDTH-1:0] prio_in;
   logic [SW-1:0] pos_m1, parent;
   logic [XW-1:0] lidx, ridx, cnt_x;
   logic [CW+8:0] cnt_ext;
   logic r_ok;
   entry_type big;
   logic [1:0] big_sel;

   assign prio_trunc = req_priority_req[TW-1:0];
   assign prio_in    = PRIO_WIDTH'(prio_trunc);
   assign pos_m1     = pos_ff - 1'b1;
   assign parent     = pos_m1 >> 1;
   assign lidx       = XW'({pos_ff, 1'b1});
   assign ridx       = lidx + 1'b1;
   assign cnt_x      = XW'(count_ff);
   assign r_ok       = ridx < cnt_x;
   assign cnt_ext    = {9'b0, count_ff};

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_removed_id  = rsp_removed_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   always_comb begin
      big     = cur_ff;
      big_sel = 2'd0;
      if ($signed(left_ff.prio) > $signed(cur_ff.prio)) begin
         big     = left_ff;
         big_sel = 2'd1;
      end
      if (r_ok && ($signed(heap_rd_ff.prio) > $signed(big.prio))) begin
         big     = heap_rd_ff;
         big_sel = 2'd2;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      cur_in     = cur_ff;
      left_in    = left_ff;
      sink_in    = sink_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      count_in   = count_ff;
      present_in = present_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      heap_we    = 1'b0;
      heap_waddr = pos_ff;
      heap_wdata = cur_ff;
      heap_raddr = '0;
      map_we     = 1'b0;
      map_waddr  = cur_ff.id;
      map_wdata  = pos_ff;
      map_raddr  = req_item_id;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               removed_in  = '0;
               status_in   = ST_OK;
               cur_in.id   = req_item_id;
               cur_in.prio = prio_in;
               state_in    = S_FIN;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (present_ff[req_item_id]) begin
                        status_in = ST_PRESENT;
                     end else begin
                        pos_in                  = count_ff[SW-1:0];
                        count_in                = count_ff + 1'b1;
                        present_in[req_item_id] = 1'b1;
                        sink_in                 = 1'b0;
                        state_in                = S_UP_RD;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                        state_in = S_EX_RD1;
                     end
                  end
                  CMD_CHANGE: begin
                     if (!present_ff[req_item_id]) begin
                        status_in = ST_ABSENT;
                     end else begin
                        sink_in  = 1'b1;
                        state_in = S_CH_POS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CH_POS: begin
            pos_in   = map_rd_ff;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            heap_raddr = parent;
            if (pos_ff == '0) state_in = sink_ff ? S_DN_RL : S_PLACE;
            else state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if ($signed(heap_rd_ff.prio) < $signed(cur_ff.prio)) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rd_ff;
               map_we     = 1'b1;
               map_waddr  = heap_rd_ff.id;
               pos_in     = parent;
               state_in   = S_UP_RD;
            end else begin
               state_in = sink_ff ? S_DN_RL : S_PLACE;
            end
         end
         S_EX_RD1: begin
            removed_in                = heap_rd_ff.id;
            present_in[heap_rd_ff.id] = 1'b0;
            heap_raddr                = count_ff[SW-1:0];
            state_in                  = S_EX_GET;
         end
         S_EX_GET: begin
            cur_in   = heap_rd_ff;
            pos_in   = '0;
            state_in = (count_ff == '0) ? S_FIN : S_DN_RL;
         end
         S_DN_RL: begin
            heap_raddr = lidx[SW-1:0];
            state_in   = (lidx < cnt_x) ? S_DN_RR : S_PLACE;
         end
         S_DN_RR: begin
            left_in    = heap_rd_ff;
            heap_raddr = ridx[SW-1:0];
            state_in   = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (big_sel == 2'd0) begin
               state_in = S_PLACE;
            end else begin
               heap_we    = 1'b1;
               heap_wdata = big;
               map_we     = 1'b1;
               map_waddr  = big.id;
               pos_in     = (big_sel == 2'd1) ? lidx[SW-1:0] : ridx[SW-1:0];
               state_in   = S_DN_RL;
            end
         end
         S_PLACE: begin
            heap_we  = 1'b1;
            map_we   = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_removed_in = removed_ff;
               rsp_status_in  = status_ff;
               rsp_count_in   = cnt_ext[8:0];
               rsp_empty_in   = (count_ff == '0);
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (heap_we) heap_ff[heap_waddr] <= heap_wdata;
      heap_rd_ff <= heap_ff[heap_raddr];
      if (map_we) map_ff[map_waddr] <= map_wdata;
      map_rd_ff <= map_ff[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      left_ff        <= left_in;
      sink_ff        <= sink_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

endmodule
